/* design/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and codes shared by the order book matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  // input item as seen on the port
  typedef struct packed {
    logic        kind;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] order_id;
  } order_t;

  // result item as seen on the port
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic [31:0] rested_quantity;
    logic [31:0] best_bid;
    logic        bid_valid;
    logic [31:0] best_ask;
    logic        ask_valid;
    logic        last;
  } result_t;

  // input kind codes
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;

  // side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // classified command codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  // result kind codes
  localparam logic [2:0] RK_TRADE     = 3'd0;
  localparam logic [2:0] RK_ADD_DONE  = 3'd1;
  localparam logic [2:0] RK_REJECTED  = 3'd2;
  localparam logic [2:0] RK_DROPPED   = 3'd3;
  localparam logic [2:0] RK_CANCELLED = 3'd4;
  localparam logic [2:0] RK_NOT_FOUND = 3'd5;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] order_id;
  } cmd_t;

  // one resting order slot
  typedef struct packed {
    logic        side;
    logic [31:0] order_id;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] stamp;
  } slot_t;

endpackage

`default_nettype wire

/* design/lobm_front.sv */
// ----------------------------------------------------------------------------
// lobm_front
// Accepts input items, classifies them and holds them in a two entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lobm_pkg::order_t order,
  output logic                 full,
  output logic                 cmd_valid,
  output lobm_pkg::cmd_t       cmd,
  input  wire logic            cmd_pop
);

  lobm_pkg::cmd_t entry [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  lobm_pkg::cmd_t cls;
  logic           do_push;
  logic           do_pop;

  // classify the incoming item
  always_comb begin
    cls.side     = order.side;
    cls.price    = order.price;
    cls.quantity = order.quantity;
    cls.order_id = order.order_id;
    if (order.kind == lobm_pkg::KIND_CANCEL) begin
      cls.op = lobm_pkg::OP_CANCEL;
    end else if (order.price == 32'd0 || order.quantity == 32'd0) begin
      cls.op = lobm_pkg::OP_REJECT;
    end else begin
      cls.op = lobm_pkg::OP_ADD;
    end
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = entry[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* design/lobm_outq.sv */
// ----------------------------------------------------------------------------
// lobm_outq
// Two entry result queue that parts the matching engine from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_push,
  input  wire lobm_pkg::result_t res,
  output logic                   res_full,
  output logic                   empty,
  output lobm_pkg::result_t      result,
  input  wire logic              pop
);

  lobm_pkg::result_t entry [2];
  logic              wp;
  logic              rp;
  logic [1:0]        cnt;
  logic              do_push;
  logic              do_pop;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign result   = entry[rp];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= res;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* design/lobm_back.sv */
// ----------------------------------------------------------------------------
// lobm_back
// Matching engine: scans the slot memory one entry a cycle to find the best
// crossing order, the cancel target or the best bid and ask.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_back #(
  parameter int ORDER_SLOTS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire lobm_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output lobm_pkg::result_t   res
);

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_TRADE = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  localparam logic [1:0] M_CROSS  = 2'd0;
  localparam logic [1:0] M_CANCEL = 2'd1;
  localparam logic [1:0] M_BBO    = 2'd2;

  logic [2:0]             state;
  logic [1:0]             mode;
  lobm_pkg::cmd_t         cur;
  logic [31:0]            qty;
  logic [CW-1:0]          nfill;
  logic [ORDER_SLOTS-1:0] used;
  logic [31:0]            counter;
  logic [CW-1:0]          scan_cnt;
  logic                   eval_vld;
  logic [IW-1:0]          eval_idx;
  logic                   found;
  lobm_pkg::slot_t        best;
  logic [IW-1:0]          best_idx;
  logic [31:0]            best_age;
  logic [31:0]            bb;
  logic                   bv;
  logic [31:0]            ba;
  logic                   av;
  logic [2:0]             fkind;
  logic [31:0]            rested;

  lobm_pkg::slot_t        mem [ORDER_SLOTS];
  lobm_pkg::slot_t        rd_data;
  logic                   issue;
  logic [IW-1:0]          raddr;
  logic                   we;
  logic [IW-1:0]          waddr;
  lobm_pkg::slot_t        wdata;

  logic                   tside;
  logic                   e_used;
  logic [31:0]            age;
  logic                   cross_ok;
  logic                   better;
  logic                   scan_last;
  logic [31:0]            fill;
  logic [31:0]            rem;
  logic [31:0]            qty_left;
  logic [CW-1:0]          nfill_inc;
  logic                   free_ok;
  logic [IW-1:0]          free_idx;

  // slot memory, registered read
  assign issue = (state == S_SCAN) && (scan_cnt < CW'(ORDER_SLOTS));
  assign raddr = scan_cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // candidate evaluation for the entry read last cycle
  assign tside     = ~cur.side;
  assign e_used    = used[eval_idx];
  assign age       = counter - rd_data.stamp;
  assign cross_ok  = e_used && (rd_data.side == tside) &&
                     (tside ? (rd_data.price <= cur.price) : (rd_data.price >= cur.price));
  assign scan_last = eval_vld && (eval_idx == IW'(ORDER_SLOTS - 1));

  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (rd_data.price != best.price) begin
      better = tside ? (rd_data.price < best.price) : (rd_data.price > best.price);
    end else begin
      better = age > best_age;
    end
  end

  // fill arithmetic
  assign fill      = (qty < best.quantity) ? qty : best.quantity;
  assign rem       = best.quantity - fill;
  assign qty_left  = qty - fill;
  assign nfill_inc = nfill + CW'(1);

  // lowest free slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = best_idx;
    wdata = best;
    if (state == S_TRADE && !res_full) begin
      we             = 1'b1;
      wdata.quantity = rem;
    end else if (state == S_PLACE && qty != 32'd0 && free_ok) begin
      we             = 1'b1;
      waddr          = free_idx;
      wdata.side     = cur.side;
      wdata.order_id = cur.order_id;
      wdata.price    = cur.price;
      wdata.quantity = qty;
      wdata.stamp    = counter;
    end
  end

  // result formation
  always_comb begin
    res      = '0;
    res_push = 1'b0;
    if (state == S_TRADE) begin
      res_push           = !res_full;
      res.result_kind    = lobm_pkg::RK_TRADE;
      res.buyer_id       = (cur.side == lobm_pkg::SIDE_BUY) ? cur.order_id : best.order_id;
      res.seller_id      = (cur.side == lobm_pkg::SIDE_BUY) ? best.order_id : cur.order_id;
      res.trade_price    = best.price;
      res.trade_quantity = fill;
    end else if (state == S_FINAL) begin
      res_push            = !res_full;
      res.result_kind     = fkind;
      res.rested_quantity = rested;
      // an empty side reports a zero price
      res.best_bid        = bv ? bb : 32'd0;
      res.bid_valid       = bv;
      res.best_ask        = av ? ba : 32'd0;
      res.ask_valid       = av;
      res.last            = 1'b1;
    end
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= M_CROSS;
      used     <= '0;
      counter  <= 32'd0;
      scan_cnt <= '0;
      eval_vld <= 1'b0;
      found    <= 1'b0;
      bv       <= 1'b0;
      av       <= 1'b0;
    end else begin
      eval_vld <= issue;
      if (issue) begin
        eval_idx <= raddr;
        scan_cnt <= scan_cnt + CW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur      <= cmd;
            qty      <= cmd.quantity;
            nfill    <= '0;
            rested   <= 32'd0;
            scan_cnt <= '0;
            found    <= 1'b0;
            bv       <= 1'b0;
            av       <= 1'b0;
            state    <= S_SCAN;
            unique case (cmd.op)
              lobm_pkg::OP_ADD:    mode <= M_CROSS;
              lobm_pkg::OP_CANCEL: mode <= M_CANCEL;
              default: begin
                mode  <= M_BBO;
                fkind <= lobm_pkg::RK_REJECTED;
              end
            endcase
          end
        end

        S_SCAN: begin
          // per entry evaluation
          if (eval_vld) begin
            unique case (mode)
              M_CROSS: begin
                if (cross_ok && better) begin
                  found    <= 1'b1;
                  best     <= rd_data;
                  best_idx <= eval_idx;
                  best_age <= age;
                end
              end
              M_CANCEL: begin
                if (e_used && rd_data.order_id == cur.order_id && !found) begin
                  found    <= 1'b1;
                  best_idx <= eval_idx;
                end
              end
              default: begin
                if (e_used && rd_data.side == lobm_pkg::SIDE_BUY) begin
                  if (!bv || rd_data.price > bb) bb <= rd_data.price;
                  bv <= 1'b1;
                end
                if (e_used && rd_data.side == lobm_pkg::SIDE_SELL) begin
                  if (!av || rd_data.price < ba) ba <= rd_data.price;
                  av <= 1'b1;
                end
              end
            endcase
          end
          // end of pass
          if (scan_last) begin
            unique case (mode)
              M_CROSS: begin
                if (found || (cross_ok && better)) begin
                  state <= S_TRADE;
                end else begin
                  state <= S_PLACE;
                end
              end
              M_CANCEL: begin
                if (found || (e_used && rd_data.order_id == cur.order_id)) begin
                  fkind <= lobm_pkg::RK_CANCELLED;
                  if (found) used[best_idx] <= 1'b0;
                  else used[eval_idx] <= 1'b0;
                end else begin
                  fkind <= lobm_pkg::RK_NOT_FOUND;
                end
                mode     <= M_BBO;
                scan_cnt <= '0;
                bv       <= 1'b0;
                av       <= 1'b0;
              end
              default: begin
                state <= S_FINAL;
              end
            endcase
          end
        end

        S_TRADE: begin
          if (!res_full) begin
            qty   <= qty_left;
            nfill <= nfill_inc;
            if (rem == 32'd0) used[best_idx] <= 1'b0;
            found <= 1'b0;
            if (qty_left != 32'd0 && nfill_inc < CW'(ORDER_SLOTS)) begin
              scan_cnt <= '0;
              state    <= S_SCAN;
            end else begin
              state <= S_PLACE;
            end
          end
        end

        S_PLACE: begin
          if (qty == 32'd0) begin
            fkind <= lobm_pkg::RK_ADD_DONE;
          end else if (free_ok) begin
            used[free_idx] <= 1'b1;
            counter        <= counter + 32'd1;
            rested         <= qty;
            fkind          <= lobm_pkg::RK_ADD_DONE;
          end else begin
            fkind <= lobm_pkg::RK_DROPPED;
          end
          mode     <= M_BBO;
          scan_cnt <= '0;
          bv       <= 1'b0;
          av       <= 1'b0;
          state    <= S_SCAN;
        end

        S_FINAL: begin
          if (!res_full) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/limit_order_book_matcher.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book with add, cancel and trade reporting.
// ----------------------------------------------------------------------------
// Input channel: drive order and raise push; the item is taken on a clock
// edge with push high and full low. Adds with zero price or quantity are
// rejected; cancels look up the resting order by id.
// Result channel: while empty is low the oldest result sits on result; raise
// pop to take it. Each item gives zero or more trades and then one final
// result with last set that carries the best bid and best ask.
// Timing: the engine walks the ORDER_SLOTS entry slot memory one entry a
// cycle with a registered read. A rejected add takes one pass and a cancel
// two, each plus a pickup step and a final result step. An add with F fills
// takes at most F + 2 passes plus a trade step per fill, one for placement,
// pickup and final result. An item waits in the input queue until the
// engine picks it up.
// A two entry queue before the engine and one after it let both sides stall
// on their own; when the receiver holds off, the engine waits on the next
// result and the input queue fills, then full rises.
// Reset empties the book, both queues and the arrival counter; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lobm_pkg::order_t  order,
  output logic                   full,
  output logic                   empty,
  output lobm_pkg::result_t      result,
  input  wire logic              pop
);

  logic              cmd_valid;
  lobm_pkg::cmd_t    cmd;
  logic              cmd_pop;
  logic              res_full;
  logic              res_push;
  lobm_pkg::result_t res;

  // intake and classification
  lobm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .order     (order),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // matching engine
  lobm_back #(
    .ORDER_SLOTS (ORDER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  lobm_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .result   (result),
    .pop      (pop)
  );

  // only trades come without the last flag
  a_nonlast_is_trade: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.last) |-> (result.result_kind == lobm_pkg::RK_TRADE))
    else $error("non-final result is not a trade");

  // a trade never fills zero
  a_trade_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.result_kind == lobm_pkg::RK_TRADE) |-> (result.trade_quantity != 32'd0))
    else $error("trade with zero quantity");

  // results leave the engine only while the result queue has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule

`default_nettype wire
